// ===== sv/bpc_pkg.sv =====
`timescale 1ns / 1ps

package bpc_pkg;

    typedef enum logic [1:0] {
        COLOR_OFF   = 2'd0,
        COLOR_RED   = 2'd1,
        COLOR_GREEN = 2'd2,
        COLOR_BLUE  = 2'd3
    } t_color;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int DEB_BITS      = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BEEP       = 2'd2;

    localparam logic [DEB_BITS-1:0]      DEBOUNCE_RESET   = 8'd40;
    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd1500;
    localparam logic [CFG_DATA_BITS-1:0] BEEP_RESET       = 16'd250;

    typedef struct packed {
        logic [1:0] lamp_color;
        logic       buzzer_on;
        logic [1:0] press_event;
    } t_result;

endpackage

// ===== sv/bpc_in_if.sv =====
`timescale 1ns / 1ps

interface bpc_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

// ===== sv/bpc_out_if.sv =====
`timescale 1ns / 1ps

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] lamp_color;
    logic       buzzer_on;
    logic [1:0] press_event;

    modport source (output valid, output lamp_color, output buzzer_on, output press_event,
                    input ready);
    modport sink (input valid, input lamp_color, input buzzer_on, input press_event,
                  output ready);
endinterface

// ===== sv/bpc_cfg.sv =====
`timescale 1ns / 1ps

module bpc_cfg
    import bpc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic [DEB_BITS-1:0]      o_debounce_load,
    output logic [TIMER_BITS-1:0]    o_long_limit,
    output logic [TIMER_BITS-1:0]    o_beep_load
);

    localparam logic [31:0] TMASK = 32'((64'(1) << TIMER_BITS) - 64'(1));

    logic [DEB_BITS-1:0]      r_debounce;
    logic [CFG_DATA_BITS-1:0] r_long_press;
    logic [CFG_DATA_BITS-1:0] r_beep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RESET;
            r_long_press <= LONG_PRESS_RESET;
            r_beep       <= BEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[DEB_BITS-1:0];
                CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                CFG_BEEP:       r_beep       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, values above the counter range saturate
    function automatic logic [TIMER_BITS-1:0] time_limit(input logic [CFG_DATA_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) w = 32'd1;
        if (w > TMASK) w = TMASK;
        return TIMER_BITS'(w);
    endfunction

    assign o_debounce_load = (r_debounce == '0) ? DEB_BITS'(1) : r_debounce;
    assign o_long_limit    = time_limit(r_long_press);
    assign o_beep_load     = time_limit(r_beep);

endmodule

// ===== sv/bpc_core.sv =====
`timescale 1ns / 1ps

module bpc_core
    import bpc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_level,
    input  logic [DEB_BITS-1:0]   i_debounce_load,
    input  logic [TIMER_BITS-1:0] i_long_limit,
    input  logic [TIMER_BITS-1:0] i_beep_load,
    output t_result               o_result
);

    logic                  r_stable, n_stable;
    logic                  r_wait, n_wait;
    logic [DEB_BITS-1:0]   r_deb, n_deb;
    logic [TIMER_BITS-1:0] r_hold, n_hold;
    logic                  r_long, n_long;
    t_color                r_color, n_color;
    logic [TIMER_BITS-1:0] r_beep, n_beep;
    t_event                ev;
    logic [DEB_BITS-1:0]   deb_dec;
    logic [1:0]            color_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_wait   <= 1'b0;
            r_deb    <= '0;
            r_hold   <= '0;
            r_long   <= 1'b0;
            r_color  <= COLOR_OFF;
            r_beep   <= '0;
        end else if (i_step) begin
            r_stable <= n_stable;
            r_wait   <= n_wait;
            r_deb    <= n_deb;
            r_hold   <= n_hold;
            r_long   <= n_long;
            r_color  <= n_color;
            r_beep   <= n_beep;
        end
    end

    always_comb begin
        n_stable  = r_stable;
        n_wait    = r_wait;
        n_deb     = r_deb;
        n_hold    = r_hold;
        n_long    = r_long;
        n_color   = r_color;
        n_beep    = (r_beep != '0) ? r_beep - TIMER_BITS'(1) : r_beep;
        ev        = EV_NONE;
        deb_dec   = (r_deb != '0) ? r_deb - DEB_BITS'(1) : r_deb;
        color_inc = r_color + 2'd1;

        if (r_stable && !r_long) begin
            n_hold = (r_hold != '1) ? r_hold + TIMER_BITS'(1) : r_hold;
            if (n_hold >= i_long_limit) begin
                n_color = COLOR_OFF;
                n_long  = 1'b1;
                ev      = EV_LONG;
            end
        end

        if (r_wait) begin
            n_deb = deb_dec;
            if (deb_dec == '0) begin
                n_wait = 1'b0;
                if (i_level != r_stable) begin
                    if (i_level) begin
                        n_stable = 1'b1;
                        n_long   = 1'b0;
                        n_hold   = '0;
                    end else begin
                        // release after a long press gives no short press
                        if (!n_long) begin
                            n_color = (color_inc == 2'd0) ? COLOR_RED : t_color'(color_inc);
                            n_beep  = i_beep_load;
                            ev      = EV_SHORT;
                        end
                        n_stable = 1'b0;
                        n_hold   = '0;
                    end
                end
            end
        end else if (i_level != r_stable) begin
            n_wait = 1'b1;
            n_deb  = i_debounce_load;
        end

        o_result.lamp_color  = n_color;
        o_result.buzzer_on   = (n_beep != '0);
        o_result.press_event = ev;
    end

endmodule

// ===== sv/button_press_classifier_led_cycler.sv =====
`timescale 1ns / 1ps

// Debounces a raw button sampled once per tick beat, classifies accepted presses as short or
// long, steps the LED color on a short press, turns it off on a long press and runs a beep
// timer alongside. One tick beat is taken every clock cycle while the result side keeps up;
// each beat gives exactly one result beat, through the input register and then the state
// update into the result register. The result register decouples the sides, so while a
// result waits one further tick is still taken into the input register. Configuration writes
// take effect on the next tick and must be made while no tick is in flight.
module button_press_classifier_led_cycler
    import bpc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    bpc_in_if.sink                   i_in,
    bpc_out_if.source                o_out
);

    logic                  r_in_valid;
    logic                  r_level;
    logic                  r_out_valid;
    t_result               r_result;
    t_result               core_result;
    logic                  advance;
    logic [DEB_BITS-1:0]   debounce_load;
    logic [TIMER_BITS-1:0] long_limit;
    logic [TIMER_BITS-1:0] beep_load;

    bpc_cfg #(.TIMER_BITS(TIMER_BITS)) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_debounce_load (debounce_load),
        .o_long_limit    (long_limit),
        .o_beep_load     (beep_load)
    );

    // the held tick moves into the result register when that slot is free or is being taken
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    bpc_core #(.TIMER_BITS(TIMER_BITS)) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_level         (r_level),
        .i_debounce_load (debounce_load),
        .i_long_limit    (long_limit),
        .i_beep_load     (beep_load),
        .o_result        (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_level <= i_in.button_level;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.lamp_color  = r_result.lamp_color;
    assign o_out.buzzer_on   = r_result.buzzer_on;
    assign o_out.press_event = r_result.press_event;

endmodule

// ===== dv/button_press_classifier_led_cycler_test.sv =====
`timescale 1ns / 1ps

module button_press_classifier_led_cycler_test;
    import bpc_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic    lvl;
        bit      chk;
        t_result want;
    } t_tick_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    bpc_in_if tick_if ();
    bpc_out_if res_if ();

    button_press_classifier_led_cycler u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_if),
        .o_out      (res_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the block state and registers
    logic [7:0]  deb_cfg;
    logic [15:0] long_cfg;
    logic [15:0] beep_cfg;
    logic        btn_held;
    logic        deb_busy;
    logic [7:0]  deb_left;
    logic [15:0] hold_ticks;
    logic        long_done;
    t_color      led_now;
    logic [15:0] beep_left;

    t_result pending_results[$];
    t_result mon_want;
    int      mismatches = 0;
    int      ticks_sent = 0;
    int unsigned cycle_cnt = 0;

    bit      tx_idle_en = 1'b1;
    bit      rx_idle_en = 1'b1;
    bit      hold_req = 1'b0;
    bit      row_chk = 1'b0;
    t_result row_want;

    // debounce 1, long press 4, beep 2
    t_tick_row dir_rows [25] = '{
        '{1'b0, 1'b1, '{COLOR_OFF, 1'b0, EV_NONE}},
        '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0},
        '{1'b0, 1'b1, '{COLOR_RED, 1'b1, EV_SHORT}},
        '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0},
        '{1'b0, 1'b0, '0},
        // long press fires on the same tick the release is accepted
        '{1'b0, 1'b1, '{COLOR_OFF, 1'b0, EV_LONG}}
    };

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic t_result classify_tick(input logic lvl);
        t_result res;
        t_event  ev;
        ev = EV_NONE;
        if (beep_left != 16'd0) begin
            beep_left = beep_left - 16'd1;
        end
        if (btn_held && !long_done) begin
            if (hold_ticks != 16'hFFFF) begin
                hold_ticks = hold_ticks + 16'd1;
            end
            if (hold_ticks >= at_least_one(long_cfg)) begin
                led_now = COLOR_OFF;
                long_done = 1'b1;
                ev = EV_LONG;
            end
        end
        if (deb_busy) begin
            if (deb_left != 8'd0) begin
                deb_left = deb_left - 8'd1;
            end
            if (deb_left == 8'd0) begin
                deb_busy = 1'b0;
                if (lvl != btn_held) begin
                    if (lvl) begin
                        btn_held = 1'b1;
                        long_done = 1'b0;
                    end else begin
                        if (!long_done) begin
                            case (led_now)
                                COLOR_RED:   led_now = COLOR_GREEN;
                                COLOR_GREEN: led_now = COLOR_BLUE;
                                default:     led_now = COLOR_RED;
                            endcase
                            beep_left = at_least_one(beep_cfg);
                            ev = EV_SHORT;
                        end
                        btn_held = 1'b0;
                    end
                    hold_ticks = 16'd0;
                end
            end
        end else if (lvl != btn_held) begin
            deb_busy = 1'b1;
            deb_left = (deb_cfg == 8'd0) ? 8'd1 : deb_cfg;
        end
        res.lamp_color = led_now;
        res.buzzer_on = (beep_left != 16'd0);
        res.press_event = ev;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:   deb_cfg = data[7:0];
            CFG_LONG_PRESS: long_cfg = data;
            CFG_BEEP:       beep_cfg = data;
            default:        ;
        endcase
        @(negedge clk);
    endtask

    task automatic send_tick(input logic lvl);
        t_result want;
        tick_if.valid <= 1'b1;
        tick_if.button_level <= lvl;
        @(posedge clk);
        while (tick_if.ready !== 1'b1) @(posedge clk);
        want = classify_tick(lvl);
        if (row_chk) begin
            want = row_want;
        end
        row_chk = 1'b0;
        pending_results.push_back(want);
        ticks_sent++;
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 9) == 0) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        tick_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // short flips that end on the opposite level
    task automatic chatter(input logic lvl);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            send_tick(lvl);
            send_tick(!lvl);
        end
    endtask

    task automatic press_sequence();
        int d;
        int l;
        int hi;
        int sel;
        d = (deb_cfg == 8'd0) ? 1 : int'(deb_cfg);
        l = int'(at_least_one(long_cfg));
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2 * d + 4)) send_tick(1'($urandom_range(0, 1)));
        end else begin
            // very long hold times are too slow to reach, keep to short presses there
            sel = (l > 4000) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            case (sel)
                0: hi = $urandom_range(1, d);
                1: hi = d + $urandom_range(1, (l < 64) ? l : 64);
                2: hi = l + $urandom_range(0, 4) - 2;
                default: hi = l + $urandom_range(3, 30);
            endcase
            if (hi < 1) begin
                hi = 1;
            end
            chatter(1'b1);
            repeat (hi) send_tick(1'b1);
            chatter(1'b0);
            repeat (d + $urandom_range(1, 10)) send_tick(1'b0);
        end
    endtask

    task automatic run_phase(input logic [7:0] deb, input logic [15:0] lp,
                             input logic [15:0] bp, input int budget, input bit squeeze);
        int start;
        logic [7:0] upper;
        drain_results();
        upper = 8'($urandom);
        write_reg(CFG_DEBOUNCE, {upper, deb});
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_BEEP, bp);
        hold_req = squeeze;
        start = ticks_sent;
        while (ticks_sent - start < budget) press_sequence();
    endtask

    task automatic report_field(input string name, input logic [1:0] want,
                                input logic [1:0] got);
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk) begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got color %0d buzz %0d ev %0d",
                         $time, res_if.lamp_color, res_if.buzzer_on, res_if.press_event);
                mismatches++;
            end else begin
                mon_want = pending_results.pop_front();
                if (res_if.lamp_color !== mon_want.lamp_color)
                    report_field("lamp_color", mon_want.lamp_color, res_if.lamp_color);
                if (res_if.buzzer_on !== mon_want.buzzer_on)
                    report_field("buzzer_on", mon_want.buzzer_on, res_if.buzzer_on);
                if (res_if.press_event !== mon_want.press_event)
                    report_field("press_event", mon_want.press_event, res_if.press_event);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (300) @(negedge clk);
                res_if.ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_DEBOUNCE;
        cfg_data = '0;
        tick_if.valid = 1'b0;
        tick_if.button_level = 1'b0;
        deb_cfg = DEBOUNCE_RESET;
        long_cfg = LONG_PRESS_RESET;
        beep_cfg = BEEP_RESET;
        btn_held = 1'b0;
        deb_busy = 1'b0;
        deb_left = '0;
        hold_ticks = '0;
        long_done = 1'b0;
        led_now = COLOR_OFF;
        beep_left = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_DEBOUNCE, 16'hC301);
        write_reg(CFG_LONG_PRESS, 16'd4);
        write_reg(CFG_BEEP, 16'd2);
        foreach (dir_rows[i]) begin
            row_chk = dir_rows[i].chk;
            row_want = dir_rows[i].want;
            send_tick(dir_rows[i].lvl);
        end

        // zero register values act as one
        run_phase(8'd0, 16'd0, 16'd0, 100, 1'b0);
        run_phase(8'd2, 16'd9, 16'd4, 150, 1'b1);
        run_phase(8'd5, 16'd30, 16'hFFFF, 100, 1'b0);
        run_phase(8'd12, 16'hFFFF, 16'd3, 100, 1'b0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_phase(8'd3, 16'd6, 16'd2, 120, 1'b0);
        drain_results();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
